// ===== src/tlbse_pkg.sv =====
package tlbse_pkg;

    localparam int MAX_SIDE = 4096;
    localparam int ROW_W    = $clog2(MAX_SIDE + 1);
    localparam int LIM_W    = 15;
    localparam int PW       = ROW_W + 13;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] OP_HDR = 2'd0;
    localparam logic [1:0] OP_PIX = 2'd1;
    localparam logic [1:0] OP_END = 2'd2;

    localparam logic [1:0] SRC_USER = 2'd0;
    localparam logic [1:0] SRC_BAND = 2'd1;
    localparam logic [1:0] SRC_BOX  = 2'd2;

    localparam logic [1:0] CFG_VIS  = 2'd0;
    localparam logic [1:0] CFG_USER = 2'd1;
    localparam logic [1:0] CFG_PAD  = 2'd2;

    localparam logic [7:0]  INK_MIN   = 8'd16;
    localparam logic [15:0] SCALE_MIN = 16'd2048;
    localparam logic [15:0] SCALE_MAX = 16'd10240;

    typedef enum logic [1:0] {
        K_NONE,
        K_HDR,
        K_FRAME
    } t_kind;

    typedef enum logic [1:0] {
        JOB_BAND,
        JOB_HDR,
        JOB_FRAME
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_MUL0,
        S_B_MUL1,
        S_B_MUL2,
        S_B_TEST,
        S_B_ACC,
        S_KIND,
        S_H_ACC,
        S_F_CHK,
        S_F_MUL0,
        S_F_MUL1,
        S_F_MUL2,
        S_F_CLAMP,
        S_F_EMIT,
        S_DIV_GO,
        S_DIV_WAIT
    } t_back_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] part_height;
        logic [12:0] part_display_height;
        logic        has_pixels;
        logic [7:0]  alpha;
        logic        row_last;
    } t_item;

    typedef struct packed {
        logic             band;
        logic [ROW_W-1:0] rows;
        logic [11:0]      band_h;
        logic [12:0]      band_dh;
        t_kind            kind;
        logic [11:0]      hdr_h;
        logic [12:0]      hdr_dh;
    } t_evt;

    typedef struct packed {
        logic [12:0] vis;
        logic [15:0] user;
        logic [7:0]  pad;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [63:0] n;
        logic [47:0] d;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } t_div_rsp;

endpackage

// ===== src/text_line_band_scale_estimator.sv =====
// Text line band scale estimator.
//
// Input stream: one beat per item. tuser carries the item kind (part header,
// pixel, end of frame); tlast marks the last pixel of a bitmap row. The front
// end takes one beat per cycle while the queue has room and tracks ink rows
// and bands itself; only band closings, headers and frame ends go on through
// a four-entry queue. The back end works the queued events one at a time
// with one shared 64-step divider; a band that fails the range test skips
// the divider, and an event that closes a band and also starts a part or
// ends the frame works the band first, then the header or frame end.
// Input is held off only while the queue is full.
// Output stream: one beat per end of frame, carrying the Q4.12 scale, the
// count of heights averaged and, in tuser, where the scale came from. The
// result is sent once earlier events are drained and the frame end is worked.
// If the receiver stalls, the result waits in the output register and the
// back end keeps draining the queue until a second result.
// Configuration writes take effect at once and must be made while idle.
// Reset (synchronous, active low) restores the register defaults and clears
// all frame state.
module text_line_band_scale_estimator
    import tlbse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // part_height[11:0], part_display_height[24:12], has_pixels[25], alpha[33:26]
    input  logic [39:0] i_s_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // scale_q12[15:0], lines_counted[31:16]
    output logic [31:0] o_m_tdata,
    // source[1:0]
    output logic [1:0]  o_m_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_item    w_item;
    logic     w_push;
    logic     w_full;
    logic     w_pop;
    logic     w_empty;
    t_evt     w_evt_in;
    t_evt     w_evt_out;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    logic [15:0] w_scale;
    logic [15:0] w_lines;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vis  <= 13'd720;
            r_cfg.user <= 16'd4096;
            r_cfg.pad  <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VIS:  r_cfg.vis  <= i_cfg_data[12:0];
                CFG_USER: r_cfg.user <= i_cfg_data;
                CFG_PAD:  r_cfg.pad  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign w_item.op                  = i_s_tuser;
    assign w_item.part_height         = i_s_tdata[11:0];
    assign w_item.part_display_height = i_s_tdata[24:12];
    assign w_item.has_pixels          = i_s_tdata[25];
    assign w_item.alpha               = i_s_tdata[33:26];
    assign w_item.row_last            = i_s_tlast;

    tlbse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_item  (w_item),
        .o_ready (o_s_tready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_evt   (w_evt_in)
    );

    tlbse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_evt_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_evt   (w_evt_out),
        .o_empty (w_empty)
    );

    tlbse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    tlbse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_empty   (w_empty),
        .i_evt     (w_evt_out),
        .o_pop     (w_pop),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_scale   (w_scale),
        .o_source  (o_m_tuser),
        .o_lines   (w_lines)
    );

    assign o_m_tdata = {w_lines, w_scale};

endmodule

// ===== src/tlbse_front.sv =====
module tlbse_front
    import tlbse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_full,
    output logic  o_push,
    output t_evt  o_evt
);

    logic             r_ink, n_ink;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_band, n_band;
    logic [ROW_W-1:0] r_first, n_first;
    logic [ROW_W-1:0] r_last, n_last;
    logic [11:0]      r_gap, n_gap;
    logic [11:0]      r_h, n_h;
    logic [12:0]      r_dh, n_dh;
    logic             r_scan, n_scan;

    logic             w_acc;
    logic             w_ink;
    logic [LIM_W-1:0] w_lim;
    logic [15:0]      w_g_prod;
    logic [5:0]       w_g;
    logic [11:0]      w_gap_new;
    logic [ROW_W-1:0] w_dist;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign w_ink   = r_ink || (i_item.alpha >= INK_MIN);
    assign w_lim   = (LIM_W'(r_h) < LIM_W'(MAX_SIDE)) ? LIM_W'(r_h) : LIM_W'(MAX_SIDE);
    assign w_dist  = r_row - r_last;

    // h/80 is (h>>4)/5, and x/5 equals (x*205)>>10 for every 8-bit x.
    assign w_g_prod  = 16'(i_item.part_height[11:4]) * 16'd205;
    assign w_g       = w_g_prod[15:10];
    assign w_gap_new = (w_g > 6'd1) ? 12'(w_g) : 12'd1;

    always_comb begin
        n_ink   = r_ink;
        n_row   = r_row;
        n_band  = r_band;
        n_first = r_first;
        n_last  = r_last;
        n_gap   = r_gap;
        n_h     = r_h;
        n_dh    = r_dh;
        n_scan  = r_scan;
        o_evt   = '0;
        o_evt.kind    = K_NONE;
        o_evt.rows    = r_last - r_first + ROW_W'(1);
        o_evt.band_h  = r_h;
        o_evt.band_dh = r_dh;
        o_evt.hdr_h   = i_item.part_height;
        o_evt.hdr_dh  = i_item.part_display_height;
        if (w_acc) begin
            case (i_item.op)
                OP_HDR: begin
                    o_evt.band = r_scan && r_band;
                    o_evt.kind = K_HDR;
                    n_h    = i_item.part_height;
                    n_dh   = i_item.part_display_height;
                    n_scan = i_item.has_pixels && (i_item.part_height != 12'd0)
                             && (i_item.part_display_height != 13'd0);
                    n_gap  = w_gap_new;
                    n_band = 1'b0;
                    n_ink  = 1'b0;
                    n_row  = '0;
                end
                OP_PIX: begin
                    n_ink = w_ink;
                    if (i_item.row_last) begin
                        if (r_scan && (LIM_W'(r_row) < w_lim)) begin
                            if (w_ink) begin
                                if (!r_band) begin
                                    n_band  = 1'b1;
                                    n_first = r_row;
                                end
                                n_last = r_row;
                            end else if (r_band && (LIM_W'(w_dist) > LIM_W'(r_gap))) begin
                                o_evt.band = 1'b1;
                                n_band     = 1'b0;
                            end
                            n_row = r_row + ROW_W'(1);
                        end
                        n_ink = 1'b0;
                    end
                end
                OP_END: begin
                    o_evt.band = r_scan && r_band;
                    o_evt.kind = K_FRAME;
                    n_ink   = 1'b0;
                    n_row   = '0;
                    n_band  = 1'b0;
                    n_first = '0;
                    n_last  = '0;
                    n_gap   = 12'd1;
                    n_h     = '0;
                    n_dh    = '0;
                    n_scan  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push = w_acc && (o_evt.band || (o_evt.kind != K_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ink   <= 1'b0;
            r_row   <= '0;
            r_band  <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
            r_gap   <= 12'd1;
            r_h     <= '0;
            r_dh    <= '0;
            r_scan  <= 1'b0;
        end else begin
            r_ink   <= n_ink;
            r_row   <= n_row;
            r_band  <= n_band;
            r_first <= n_first;
            r_last  <= n_last;
            r_gap   <= n_gap;
            r_h     <= n_h;
            r_dh    <= n_dh;
            r_scan  <= n_scan;
        end
    end

endmodule

// ===== src/tlbse_fifo.sv =====
module tlbse_fifo
    import tlbse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    output logic o_full,
    input  logic i_pop,
    output t_evt o_evt,
    output logic o_empty
);

    t_evt           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_evt   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

endmodule

// ===== src/tlbse_div.sv =====
module tlbse_div
    import tlbse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [47:0] r_rem;
    logic [63:0] r_q;
    logic [47:0] r_d;

    logic [48:0] w_sh;
    logic        w_ge;
    logic [48:0] w_twice;
    logic        w_up;

    assign w_sh    = {r_rem, r_q[63]};
    assign w_ge    = (w_sh >= {1'b0, r_d});
    assign w_twice = {r_rem, 1'b0};
    // Round half to even on the final remainder.
    assign w_up    = (w_twice > {1'b0, r_d}) || ((w_twice == {1'b0, r_d}) && r_q[0]);

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.n;
            r_d   <= i_req.d;
        end else if (r_busy && (r_cnt != 7'd0)) begin
            r_rem <= w_ge ? 48'(w_sh - {1'b0, r_d}) : w_sh[47:0];
            r_q   <= {r_q[62:0], w_ge};
        end else if (r_busy) begin
            r_q <= (r_d == '0) ? '0 : (r_q + 64'(w_up));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy && (r_cnt != 7'd0)) begin
                r_cnt <= r_cnt - 7'd1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

// ===== src/tlbse_back.sv =====
module tlbse_back
    import tlbse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_empty,
    input  t_evt        i_evt,
    output logic        o_pop,
    output t_div_req    o_div_req,
    input  t_div_rsp    i_div_rsp,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_scale,
    output logic [1:0]  o_source,
    output logic [15:0] o_lines
);

    t_back_state r_state, n_state;
    t_evt        r_e;
    t_job        r_job;

    logic [PW-1:0]    r_p;
    logic [24:0]      r_vh;
    logic [PW+10:0]   r_a;
    logic [28:0]      r_b;
    logic [PW+6:0]    r_c;
    logic             r_ok1;
    logic [28:0]      r_vu;
    logic [32:0]      r_base;
    logic [63:0]      r_num;
    logic [47:0]      r_den;

    logic [39:0] r_line_sum;
    logic [15:0] r_line_cnt;
    logic [31:0] r_box_sum;
    logic [15:0] r_box_cnt;
    logic [15:0] r_parts;

    logic [15:0] r_res_scale;
    logic [1:0]  r_res_src;
    logic [15:0] r_res_cnt;

    logic        r_o_valid;
    logic [15:0] r_o_scale;
    logic [1:0]  r_o_src;
    logic [15:0] r_o_cnt;

    logic        w_ok;
    logic        w_load;
    logic        w_pass;
    logic        w_use_band;
    logic        w_use_box;
    logic [64:0] w_pad2;
    logic [12:0] w_height;
    logic [48:0] w_prod_n;

    assign w_ok = r_ok1 && (64'(r_c) <= (64'(r_b) << 1)) && (r_line_cnt != 16'hFFFF);
    assign w_pass = (i_cfg.user == '0) || (i_cfg.vis == '0) || (r_parts == '0);
    assign w_use_band = (r_line_cnt != '0) && (r_line_sum != '0);
    assign w_use_box  = (r_box_cnt != '0) && (r_box_sum != '0);
    assign w_pad2   = (r_e.hdr_h == '0) ? '0 : {i_div_rsp.q, 1'b0};
    assign w_height = r_e.hdr_dh - w_pad2[12:0];
    assign w_prod_n = 49'(r_base) * 49'(r_res_cnt);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = i_evt.band ? S_B_MUL0 : S_KIND;
                end
            end
            S_B_MUL0: n_state = S_B_MUL1;
            S_B_MUL1: n_state = S_B_MUL2;
            S_B_MUL2: n_state = S_B_TEST;
            S_B_TEST: n_state = w_ok ? S_DIV_GO : S_KIND;
            S_B_ACC:  n_state = S_KIND;
            S_KIND: begin
                case (r_e.kind)
                    K_HDR:   n_state = (r_e.hdr_h != '0) ? S_DIV_GO : S_H_ACC;
                    K_FRAME: n_state = S_F_CHK;
                    default: n_state = S_IDLE;
                endcase
            end
            S_H_ACC:  n_state = S_IDLE;
            S_F_CHK:  n_state = (w_pass || !(w_use_band || w_use_box)) ? S_F_EMIT : S_F_MUL0;
            S_F_MUL0: n_state = S_F_MUL1;
            S_F_MUL1: n_state = S_F_MUL2;
            S_F_MUL2: n_state = S_DIV_GO;
            S_F_CLAMP: n_state = S_F_EMIT;
            S_F_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_div_rsp.done) begin
                    case (r_job)
                        JOB_BAND: n_state = S_B_ACC;
                        JOB_HDR:  n_state = S_H_ACC;
                        default:  n_state = S_F_CLAMP;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_pop           = (r_state == S_IDLE) && !i_empty;
        o_div_req.start = (r_state == S_DIV_GO);
        o_div_req.n     = r_num;
        o_div_req.d     = r_den;
        w_load          = (r_state == S_F_EMIT) && (!r_o_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_e <= i_evt;
            end
            S_B_MUL0: begin
                r_p  <= PW'(r_e.rows) * PW'(r_e.band_dh);
                r_vh <= 25'(i_cfg.vis) * 25'(r_e.band_h);
            end
            S_B_MUL1: begin
                r_a <= (PW+11)'(r_p) * (PW+11)'(1250);
                r_b <= 29'(r_vh) * 29'(13);
            end
            S_B_MUL2: begin
                r_c   <= (PW+7)'(r_p) * (PW+7)'(125);
                r_ok1 <= (64'(r_a) >= 64'(r_b));
            end
            S_B_TEST: begin
                r_num <= 64'(r_p) << 8;
                r_den <= 48'(r_e.band_h);
                r_job <= JOB_BAND;
            end
            S_KIND: begin
                r_num <= 64'(21'(r_e.hdr_dh) * 21'(i_cfg.pad));
                r_den <= 48'(r_e.hdr_h);
                r_job <= JOB_HDR;
            end
            S_F_CHK: begin
                r_job <= JOB_FRAME;
                if (w_pass || !(w_use_band || w_use_box)) begin
                    r_res_scale <= i_cfg.user;
                    r_res_src   <= SRC_USER;
                    r_res_cnt   <= '0;
                end else if (w_use_band) begin
                    r_res_src <= SRC_BAND;
                    r_res_cnt <= r_line_cnt;
                    r_den     <= (48'(r_line_sum) << 8) - (48'(r_line_sum) << 2)
                                 - (48'(r_line_sum) << 1);
                end else begin
                    r_res_src <= SRC_BOX;
                    r_res_cnt <= r_box_cnt;
                    r_den     <= (48'(r_box_sum) << 8) - (48'(r_box_sum) << 2)
                                 - (48'(r_box_sum) << 1);
                end
            end
            S_F_MUL0: begin
                r_vu <= 29'(i_cfg.vis) * 29'(i_cfg.user);
            end
            S_F_MUL1: begin
                r_base <= 33'(r_vu) * 33'(13);
            end
            S_F_MUL2: begin
                r_num <= (r_res_src == SRC_BAND) ? (64'(w_prod_n) << 8) : 64'(w_prod_n);
            end
            S_F_CLAMP: begin
                if (i_div_rsp.q < 64'(SCALE_MIN)) begin
                    r_res_scale <= SCALE_MIN;
                end else if (i_div_rsp.q > 64'(SCALE_MAX)) begin
                    r_res_scale <= SCALE_MAX;
                end else begin
                    r_res_scale <= i_div_rsp.q[15:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Frame accumulators and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_sum <= '0;
            r_line_cnt <= '0;
            r_box_sum  <= '0;
            r_box_cnt  <= '0;
            r_parts    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == S_B_ACC) begin
                r_line_sum <= r_line_sum + i_div_rsp.q[39:0];
                r_line_cnt <= r_line_cnt + 16'd1;
            end
            if (r_state == S_H_ACC) begin
                if ((w_pad2 < 65'(r_e.hdr_dh)) && (r_box_cnt != 16'hFFFF)) begin
                    r_box_sum <= r_box_sum + 32'(w_height);
                    r_box_cnt <= r_box_cnt + 16'd1;
                end
                if (r_parts != 16'hFFFF) begin
                    r_parts <= r_parts + 16'd1;
                end
            end
            if (w_load) begin
                r_o_valid  <= 1'b1;
                r_line_sum <= '0;
                r_line_cnt <= '0;
                r_box_sum  <= '0;
                r_box_cnt  <= '0;
                r_parts    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_scale <= r_res_scale;
            r_o_src   <= r_res_src;
            r_o_cnt   <= r_res_cnt;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_scale  = r_o_scale;
    assign o_source = r_o_src;
    assign o_lines  = r_o_cnt;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_src != SRC_USER)) |->
        ((r_o_scale >= SCALE_MIN) && (r_o_scale <= SCALE_MAX)))
        else $error("computed scale outside its clamp range");

    a_pass_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_src == SRC_USER)) |-> (r_o_cnt == '0))
        else $error("pass-through result carries a count");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> ((r_line_cnt == '0) && (r_box_cnt == '0) && (r_parts == '0)))
        else $error("frame totals not cleared after the result");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tlbse_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] ph;
        logic [12:0] pdh;
        logic        pix;
        logic [7:0]  alpha;
        logic        rlast;
    } beat_t;

    typedef struct {
        logic [15:0] scale;
        logic [1:0]  src;
        logic [15:0] cnt;
    } scale_res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    text_line_band_scale_estimator uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    beat_t      pending_beats[$];
    scale_res_t expected_scales[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_recv = 0;
    int         mismatches = 0;
    longint     cycles = 0;

    // Predictor state.
    logic [12:0] m_vis;
    logic [15:0] m_user;
    logic [7:0]  m_pad;
    logic        m_row_ink, m_band_active, m_scan;
    logic [31:0] m_row_index, m_first, m_last_ink, m_gap, m_h, m_dh;
    logic [39:0] m_line_sum;
    logic [31:0] m_line_cnt, m_box_sum, m_box_cnt, m_parts;

    function automatic logic [63:0] div_even(logic [63:0] n, logic [63:0] d);
        logic [63:0] q, r;
        if (d == 0) return 0;
        q = n / d;
        r = n % d;
        if (2 * r > d || (2 * r == d && q[0])) q++;
        return q;
    endfunction

    task automatic clear_frame_state();
        m_row_ink = 0; m_row_index = 0; m_band_active = 0; m_first = 0;
        m_last_ink = 0; m_gap = 1; m_h = 0; m_dh = 0; m_scan = 0;
        m_line_sum = 0; m_line_cnt = 0; m_box_sum = 0; m_box_cnt = 0; m_parts = 0;
    endtask

    task automatic add_band(logic [31:0] rows);
        logic [63:0] prod, v;
        prod = 64'(rows) * m_dh;
        v = 64'(m_vis);
        if (m_h == 0 || m_line_cnt >= 65535) return;
        if (prod * 1250 >= v * 13 * m_h && prod * 125 <= v * 26 * m_h) begin
            m_line_sum = m_line_sum + 40'(div_even(prod * 256, 64'(m_h)));
            m_line_cnt++;
        end
    endtask

    task automatic close_part();
        if (m_scan && m_band_active) add_band(m_last_ink - m_first + 1);
        m_band_active = 0; m_scan = 0; m_row_ink = 0; m_row_index = 0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_VIS:  m_vis = val[12:0];
            CFG_USER: m_user = val;
            default:  m_pad = val[7:0];
        endcase
    endtask

    task automatic predict_beat(beat_t b);
        logic [63:0] pad, base, r;
        logic signed [63:0] ht;
        logic [31:0] lim;
        scale_res_t res;
        case (b.op)
            OP_HDR: begin
                close_part();
                pad = 0;
                if (b.ph > 0) pad = div_even(64'(m_pad) * b.pdh, 64'(b.ph));
                ht = $signed(64'(b.pdh)) - $signed(2 * pad);
                if (ht > 0 && m_box_cnt < 65535) begin
                    m_box_sum += 32'(ht); m_box_cnt++;
                end
                if (m_parts < 65535) m_parts++;
                m_h = b.ph; m_dh = b.pdh;
                m_scan = b.pix && b.ph > 0 && b.pdh > 0;
                m_gap = (b.ph / 80 > 1) ? b.ph / 80 : 1;
            end
            OP_PIX: begin
                lim = (m_h < MAX_SIDE) ? m_h : MAX_SIDE;
                if (b.alpha >= INK_MIN) m_row_ink = 1;
                if (b.rlast) begin
                    if (m_scan && m_row_index < lim) begin
                        if (m_row_ink) begin
                            if (!m_band_active) begin
                                m_band_active = 1; m_first = m_row_index;
                            end
                            m_last_ink = m_row_index;
                        end else if (m_band_active && m_row_index - m_last_ink > m_gap) begin
                            add_band(m_last_ink - m_first + 1);
                            m_band_active = 0;
                        end
                        m_row_index++;
                    end
                    m_row_ink = 0;
                end
            end
            OP_END: begin
                close_part();
                res.scale = m_user; res.src = SRC_USER; res.cnt = 0;
                if (m_user != 0 && m_vis != 0 && m_parts != 0) begin
                    base = 64'(m_vis) * 13 * m_user;
                    r = 0;
                    if (m_line_cnt > 0 && m_line_sum > 0) begin
                        r = div_even(base * 256 * m_line_cnt, 250 * 64'(m_line_sum));
                        res.src = SRC_BAND; res.cnt = m_line_cnt[15:0];
                    end else if (m_box_cnt > 0 && m_box_sum > 0) begin
                        r = div_even(base * m_box_cnt, 250 * 64'(m_box_sum));
                        res.src = SRC_BOX; res.cnt = m_box_cnt[15:0];
                    end
                    if (res.src != SRC_USER) begin
                        if (r < SCALE_MIN) r = SCALE_MIN;
                        if (r > SCALE_MAX) r = SCALE_MAX;
                        res.scale = r[15:0];
                    end
                end
                expected_scales.push_back(res);
                clear_frame_state();
            end
            default: ;
        endcase
    endtask

    // Driver: one beat presented at a time, predicted when accepted.
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            predict_beat(pending_beats.pop_front());
        end
        if ((!i_s_tvalid || o_s_tready) && i_rst_n) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= pending_beats[0].op;
                i_s_tlast  <= pending_beats[0].rlast;
                i_s_tdata  <= {6'd0, pending_beats[0].alpha, pending_beats[0].pix,
                               pending_beats[0].pdh, pending_beats[0].ph};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        scale_res_t e;
        cycles <= cycles + 1;
        if (hold_recv > 0) hold_recv <= hold_recv - 1;
        if (o_m_tvalid && i_m_tready) begin
            if (expected_scales.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h/%h", o_m_tdata, o_m_tuser);
            end else begin
                e = expected_scales.pop_front();
                if (o_m_tdata[15:0] !== e.scale || o_m_tuser !== e.src ||
                    o_m_tdata[31:16] !== e.cnt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp scale %0d src %0d cnt %0d, got %0d %0d %0d",
                                 e.scale, e.src, e.cnt, o_m_tdata[15:0], o_m_tuser,
                                 o_m_tdata[31:16]);
                end
            end
        end
        i_m_tready <= i_rst_n && hold_recv <= 1 && $urandom_range(99) >= recv_idle_pct;
        if (cycles > 3000000) begin
            $display("text_line_band_scale_estimator regression: fail");
            $finish;
        end
    end

    function automatic beat_t hdr(int h, int dh, bit pix);
        beat_t b;
        b = '{OP_HDR, 12'(h), 13'(dh), pix, 8'd0, 1'b0};
        return b;
    endfunction

    function automatic beat_t pixel(int a, bit last);
        beat_t b;
        b = '{OP_PIX, 12'($urandom), 13'($urandom), 1'($urandom), 8'(a), last};
        return b;
    endfunction

    function automatic beat_t frame_end();
        beat_t b;
        b = '{OP_END, 12'($urandom), 13'($urandom), 1'($urandom), 8'($urandom), 1'($urandom)};
        return b;
    endfunction

    // Queue a part whose rows are mostly structured text-like bands.
    task automatic queue_part(output int n);
        int h, w, rows, dh, a;
        bit ink;
        n = 1;
        h = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 30);
        dh = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(10, 700);
        pending_beats.push_back(hdr(h, dh, $urandom_range(7) != 0));
        rows = (h > 40) ? $urandom_range(40) : h + $urandom_range(2) - 1;
        w = $urandom_range(1, 3);
        for (int r = 0; r < rows; r++) begin
            ink = $urandom_range(2) != 0;
            for (int c = 0; c < w; c++) begin
                a = ink && c == w - 1 ? $urandom_range(16, 255) : $urandom_range(15);
                if ($urandom_range(29) == 0) a = $urandom_range(255);
                pending_beats.push_back(pixel(a, c == w - 1));
                n++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || i_s_tvalid || expected_scales.size() > 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    initial begin
        int sent, n;
        m_vis = 720; m_user = 4096; m_pad = 0;
        clear_frame_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_PAD, 16'd2);

        // Directed: stray pixel, op 3, edge headers, extremes.
        pending_beats.push_back(pixel(255, 1));
        pending_beats.push_back('{2'd3, 12'hfff, 13'h1fff, 1'b1, 8'hff, 1'b1});
        pending_beats.push_back(frame_end());
        pending_beats.push_back(hdr(4095, 8191, 1));
        pending_beats.push_back(pixel(16, 0));
        pending_beats.push_back(pixel(0, 1));
        pending_beats.push_back(pixel(15, 1));
        pending_beats.push_back(pixel(255, 1));
        pending_beats.push_back(hdr(0, 100, 1));
        pending_beats.push_back(pixel(200, 1));
        pending_beats.push_back(hdr(3, 0, 1));
        pending_beats.push_back(hdr(2, 60, 0));
        pending_beats.push_back(pixel(99, 1));
        pending_beats.push_back(frame_end());
        pending_beats.push_back(hdr(2, 40, 1));
        pending_beats.push_back(pixel(255, 1));
        pending_beats.push_back(pixel(255, 1));
        pending_beats.push_back(pixel(255, 1));
        pending_beats.push_back(frame_end());
        send_idle_pct = 15; recv_idle_pct = 84;
        wait_drained();

        sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(CFG_VIS, 16'd8191); write_reg(CFG_USER, 16'hffff);
                          write_reg(CFG_PAD, 16'd255); end
                1: begin write_reg(CFG_VIS, 16'd0); write_reg(CFG_USER, 16'd1); end
                2: begin write_reg(CFG_VIS, 16'd480); write_reg(CFG_USER, 16'd0);
                          send_idle_pct = 84; recv_idle_pct = 15; end
                3: begin write_reg(CFG_VIS, 16'd1); write_reg(CFG_USER, 16'd4096);
                          write_reg(CFG_PAD, 16'd0); end
                4: begin write_reg(CFG_VIS, 16'd720); write_reg(CFG_USER, 16'd5000);
                          write_reg(CFG_PAD, 16'd3); send_idle_pct = 0; recv_idle_pct = 0; end
                default: begin write_reg(CFG_VIS, 16'd300); write_reg(CFG_PAD, 16'd1); end
            endcase
            for (int f = 0; f < 5 || sent < (phase + 1) * 110; f++) begin
                for (int p = $urandom_range(3); p > 0; p--) begin
                    queue_part(n);
                    sent += n;
                end
                pending_beats.push_back(frame_end());
                sent++;
                if (phase == 4 && f == 2) begin
                    // Long receiver stall so the event queue fills.
                    hold_recv = 3000;
                end
                while (pending_beats.size() > 8) @(posedge i_clk);
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_scales.size() == 0)
            $display("text_line_band_scale_estimator regression: pass");
        else
            $display("text_line_band_scale_estimator regression: fail");
        $finish;
    end
endmodule
